@@ rtl/core/skvs_pkg.sv @@
package skvs_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;

    localparam logic       MODE_LOOKUP = 1'b0;
    localparam logic       MODE_SET    = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // per-cell write control for the update cycle
    typedef struct packed {
        logic shift;     // take key and value from the lower neighbour
        logic load;      // take the key and value of the item
        logic wr_value;  // overwrite only the value
    } t_cell_ctl;

endpackage

@@ rtl/core/sorted_key_value_store_core.sv @@
// sorted key-value store, kept as a row of cells in ascending key order
//
// input channel: i_in_valid / o_in_stall carry one item (i_mode, i_key,
// i_value). mode lookup returns the value held for the key or status missing,
// mode set overwrites a present key or inserts a new one at its sorted place,
// or returns status full when no cell is free. output channel: o_out_valid /
// i_out_stall carry one result per item (o_found, o_stored_value, o_status).
//
// an item is accepted and registered, then in the compare step every cell
// compares its key with the item key in parallel, then in the update step the
// cells above the insert point all move up by one slot at once and the result
// is registered. the update waits while a result is held under i_out_stall.
// no new item is taken while the shared cell row is in its compare step.
//
// reset empties the store (entry count zero). while a result waits under
// i_out_stall the next item may still be accepted and compared, but its
// update waits until the result register is free, and o_in_stall stays high.
module sorted_key_value_store_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic [skvs_pkg::KEY_W-1:0]           i_key,
    input  logic signed [skvs_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    output logic signed [skvs_pkg::VALUE_W-1:0]  o_stored_value,
    output logic [1:0]                           o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                                r_cmp_v;
    logic                                r_upd_v;
    logic                                r_out_v;
    logic [CW-1:0]                       r_count;
    logic                                r_mode;
    logic [skvs_pkg::KEY_W-1:0]          r_key;
    logic signed [skvs_pkg::VALUE_W-1:0] r_value;
    logic                                r_found;
    logic signed [skvs_pkg::VALUE_W-1:0] r_stored_value;
    logic [1:0]                          r_status;

    logic                                n_found;
    logic signed [skvs_pkg::VALUE_W-1:0] n_stored_value;
    logic [1:0]                          n_status;
    logic                                n_insert;

    logic                                w_upd_go;
    logic                                w_in_acc;
    logic                                w_present;
    logic                                w_full;
    logic signed [skvs_pkg::VALUE_W-1:0] w_hit_value;

    logic [skvs_pkg::KEY_W-1:0]          w_cell_key   [CAPACITY];
    logic signed [skvs_pkg::VALUE_W-1:0] w_cell_value [CAPACITY];
    logic [CAPACITY-1:0]                 w_lt;
    logic [CAPACITY-1:0]                 w_eq;
    skvs_pkg::t_cell_ctl                 w_ctl        [CAPACITY];

    assign w_upd_go   = r_upd_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_cmp_v || (r_upd_v && !w_upd_go);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
            r_upd_v <= 1'b0;
            r_out_v <= 1'b0;
            r_count <= '0;
        end else begin
            r_cmp_v <= w_in_acc;
            r_upd_v <= r_cmp_v || (r_upd_v && !w_upd_go);
            r_out_v <= w_upd_go || (r_out_v && i_out_stall);
            if (w_upd_go && n_insert) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (w_upd_go) begin
            r_found        <= n_found;
            r_stored_value <= n_stored_value;
            r_status       <= n_status;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                                w_occ;
            logic                                w_lt_prev;
            logic [skvs_pkg::KEY_W-1:0]          w_prev_key;
            logic signed [skvs_pkg::VALUE_W-1:0] w_prev_value;

            assign w_occ = CW'(g) < r_count;

            if (g == 0) begin : g_first
                assign w_lt_prev    = 1'b1;
                assign w_prev_key   = r_key;
                assign w_prev_value = r_value;
            end else begin : g_rest
                assign w_lt_prev    = w_lt[g-1];
                assign w_prev_key   = w_cell_key[g-1];
                assign w_prev_value = w_cell_value[g-1];
            end

            // the insert point is the first cell that is empty or whose key is not below the item key
            always_comb begin
                w_ctl[g].load     = w_upd_go && n_insert && w_lt_prev && !w_lt[g];
                w_ctl[g].shift    = w_upd_go && n_insert && !w_lt_prev;
                w_ctl[g].wr_value = w_upd_go && (r_mode == skvs_pkg::MODE_SET) && w_eq[g];
            end

            skvs_cell u_cell (
                .i_clk        (i_clk),
                .i_cmp_en     (r_cmp_v),
                .i_occ        (w_occ),
                .i_req_key    (r_key),
                .i_ctl        (w_ctl[g]),
                .i_prev_key   (w_prev_key),
                .i_prev_value (w_prev_value),
                .i_new_value  (r_value),
                .o_key        (w_cell_key[g]),
                .o_value      (w_cell_value[g]),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g])
            );
        end
    endgenerate

    assign w_present = |w_eq;
    assign w_full    = r_count == CW'(CAPACITY);

    // at most one cell matches, so an and-or select picks its value
    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_value = w_hit_value | (w_cell_value[i] & {skvs_pkg::VALUE_W{w_eq[i]}});
        end
    end

    always_comb begin
        n_found        = w_present;
        n_stored_value = '0;
        n_status       = skvs_pkg::ST_OK;
        n_insert       = 1'b0;
        unique case (r_mode)
            skvs_pkg::MODE_LOOKUP: begin
                if (w_present) begin
                    n_stored_value = w_hit_value;
                end else begin
                    n_status = skvs_pkg::ST_MISSING;
                end
            end
            skvs_pkg::MODE_SET: begin
                priority if (w_present) begin
                    n_stored_value = r_value;
                end else if (w_full) begin
                    n_status = skvs_pkg::ST_FULL;
                end else begin
                    n_insert       = 1'b1;
                    n_stored_value = r_value;
                end
            end
            default: begin
                n_status = skvs_pkg::ST_OK;
            end
        endcase
    end

    assign o_out_valid    = r_out_v;
    assign o_found        = r_found;
    assign o_stored_value = r_stored_value;
    assign o_status       = r_status;

    a_cmp_upd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cmp_v && r_upd_v))
        else $error("compare and update overlap");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd_v |-> $onehot0(w_eq))
        else $error("more than one cell matches the key");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd_go && n_insert) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the store");

endmodule

@@ rtl/core/skvs_cell.sv @@
module skvs_cell (
    input  logic                                 i_clk,
    input  logic                                 i_cmp_en,
    input  logic                                 i_occ,
    input  logic [skvs_pkg::KEY_W-1:0]           i_req_key,
    input  skvs_pkg::t_cell_ctl                  i_ctl,
    input  logic [skvs_pkg::KEY_W-1:0]           i_prev_key,
    input  logic signed [skvs_pkg::VALUE_W-1:0]  i_prev_value,
    input  logic signed [skvs_pkg::VALUE_W-1:0]  i_new_value,
    output logic [skvs_pkg::KEY_W-1:0]           o_key,
    output logic signed [skvs_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_lt,
    output logic                                 o_eq
);

    logic [skvs_pkg::KEY_W-1:0]          r_key;
    logic signed [skvs_pkg::VALUE_W-1:0] r_value;
    logic                                r_lt;
    logic                                r_eq;

    // compare flags are registered so the update cycle sees only local bits
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_lt <= i_occ && (r_key < i_req_key);
            r_eq <= i_occ && (r_key == i_req_key);
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end else if (i_ctl.load) begin
            r_key   <= i_req_key;
            r_value <= i_new_value;
        end else if (i_ctl.wr_value) begin
            r_value <= i_new_value;
        end else begin
            r_key   <= r_key;
            r_value <= r_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule
